>>> rtl/gld_pkg.sv
package gld_pkg;

   // Widths fixed by the register and result formats.
   localparam int CfgW    = 11;
   localparam int PeakW   = 10;
   localparam int CsrIdxW = 8;

   // Configuration register indexes.
   localparam logic [CsrIdxW-1:0] RegFrameRows = CsrIdxW'(0);
   localparam logic [CsrIdxW-1:0] RegFrameCols = CsrIdxW'(1);

   // Pending results of one item, one bit per kind of decision.
   typedef struct packed {
      logic final_pos;   // the last sample of the frame, decided on itself
      logic left_pos;    // last-row position to the left of the current item
      logic upper_pos;   // position in the row above the current item
   } peak_mask_type;

endpackage

>>> rtl/gld_if.sv
interface gld_req_if #(
   parameter int SAMPLE_WIDTH = 16
);
   logic                           valid;
   logic                           ready;
   logic signed [SAMPLE_WIDTH-1:0] sample;

   modport source (output valid, output sample, input ready);
   modport sink   (input valid, input sample, output ready);
endinterface

interface gld_rsp_if;
   logic                        valid;
   logic                        ready;
   logic [gld_pkg::PeakW-1:0]   peak_row;
   logic [gld_pkg::PeakW-1:0]   peak_col;
   logic                        last_of_item;

   modport source (output valid, output peak_row, output peak_col, output last_of_item,
                   input ready);
   modport sink   (input valid, input peak_row, input peak_col, input last_of_item,
                   output ready);
endinterface

interface gld_csr_if;
   logic                          valid;
   logic                          ready;
   logic [gld_pkg::CsrIdxW-1:0]   index;
   logic [gld_pkg::CfgW-1:0]      data;

   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

>>> rtl/grid_local_maximum_detector.sv
// Finds the local maxima of a frame of signed samples that arrives in raster order, one
// sample per item, and returns the row and column of every sample that is greater than or
// equal to each of its existing 4-neighbours. A position is decided when the sample below
// it arrives; in the last row, when the sample to its right arrives, and the final sample
// of the frame decides itself, so the results of the last two rows interleave. Results
// carry last_of_item on the final result caused by one sample. The block takes one item
// per clock cycle while stage 2 is free; the rate is set by the single line store, read
// at two addresses and written at one per item. Results leave through one output register
// at one per cycle unless stalled, so a last-row item with two or three results holds the
// input until its last result is handed on. A sample is decided in the cycle after it is
// taken; its results pass stage 2 and the output register. There is no clearing pass
// after reset: every line store entry that a decision uses was written earlier in the
// same frame. Writing either frame dimension restarts the frame at row 0, column 0;
// values below 2 act as 2 and values above MAX_ROWS or MAX_COLS act as that maximum.
module grid_local_maximum_detector #(
   parameter int MAX_ROWS     = 1024,
   parameter int MAX_COLS     = 1024,
   parameter int SAMPLE_WIDTH = 16
) (
   input  logic      clock,
   input  logic      reset,
   gld_req_if.sink   req_ch,
   gld_rsp_if.source rsp_ch,
   gld_csr_if.sink   csr_ch
);

   localparam int ROW_W  = $clog2(MAX_ROWS);
   localparam int COL_W  = $clog2(MAX_COLS);
   localparam int PeakW  = gld_pkg::PeakW;
   localparam int W      = SAMPLE_WIDTH;

   // ---------------------------------------------------------------------------------
   // Frame dimensions, held as the index of the last row and of the last column.
   // ---------------------------------------------------------------------------------
   logic [ROW_W-1:0] last_row_ff, last_row_in;
   logic [COL_W-1:0] last_col_ff, last_col_in;
   logic [31:0]      csr_val;
   logic [31:0]      rows_clamp;
   logic [31:0]      cols_clamp;
   logic             csr_wr;
   logic             csr_hit;

   assign csr_ch.ready = 1'b1;
   assign csr_wr       = csr_ch.valid;
   assign csr_val      = 32'(csr_ch.data);
   assign csr_hit      = csr_wr && (csr_ch.index == gld_pkg::RegFrameRows ||
                                    csr_ch.index == gld_pkg::RegFrameCols);

   always_comb begin
      if (csr_val < 32'd2) begin
         rows_clamp = 32'd2;
         cols_clamp = 32'd2;
      end else begin
         rows_clamp = (csr_val > 32'(MAX_ROWS)) ? 32'(MAX_ROWS) : csr_val;
         cols_clamp = (csr_val > 32'(MAX_COLS)) ? 32'(MAX_COLS) : csr_val;
      end
      last_row_in = ROW_W'(rows_clamp - 32'd1);
      last_col_in = COL_W'(cols_clamp - 32'd1);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         last_row_ff <= ROW_W'(1);
         last_col_ff <= COL_W'(1);
      end else if (csr_wr) begin
         unique case (csr_ch.index)
            gld_pkg::RegFrameRows: last_row_ff <= last_row_in;
            gld_pkg::RegFrameCols: last_col_ff <= last_col_in;
            default: ;
         endcase
      end
   end

   // ---------------------------------------------------------------------------------
   // Handshake and pipeline control.
   // Stage 1 holds an item with its line store data and makes its decisions; stage 2
   // holds the pending results of one item and hands them to the output register.
   // ---------------------------------------------------------------------------------
   logic                  s1_valid_ff;
   logic                  s1_adv;
   logic                  req_accept;
   gld_pkg::peak_mask_type s2_mask_ff, s2_mask_in;
   gld_pkg::peak_mask_type s1_mask;
   gld_pkg::peak_mask_type s2_sel;
   gld_pkg::peak_mask_type s2_rest;
   logic                  s2_emit;
   logic                  s2_free;
   logic                  rsp_valid_ff;

   assign s2_emit      = (s2_mask_ff != '0) && (!rsp_valid_ff || rsp_ch.ready);
   // Oldest result first: the upper position, then the left one, then the final sample.
   always_comb begin
      s2_sel = '0;
      if (s2_mask_ff.upper_pos) begin
         s2_sel.upper_pos = 1'b1;
      end else if (s2_mask_ff.left_pos) begin
         s2_sel.left_pos = 1'b1;
      end else begin
         s2_sel.final_pos = s2_mask_ff.final_pos;
      end
   end
   assign s2_rest      = s2_mask_ff & ~s2_sel;
   assign s2_free      = (s2_mask_ff == '0) || (s2_emit && s2_rest == '0);
   assign s1_adv       = s1_valid_ff && s2_free;
   assign req_ch.ready = !s1_valid_ff || s1_adv;
   assign req_accept   = req_ch.valid && req_ch.ready;

   // ---------------------------------------------------------------------------------
   // Position of the next item.
   // ---------------------------------------------------------------------------------
   logic [ROW_W-1:0] row_cnt_ff;
   logic [COL_W-1:0] col_cnt_ff;
   logic             at_last_col;
   logic             at_last_row;

   assign at_last_col = (col_cnt_ff == last_col_ff);
   assign at_last_row = (row_cnt_ff == last_row_ff);

   always_ff @(posedge clock) begin
      if (reset || csr_hit) begin
         row_cnt_ff <= '0;
         col_cnt_ff <= '0;
      end else if (req_accept) begin
         if (at_last_col) begin
            col_cnt_ff <= '0;
            row_cnt_ff <= at_last_row ? '0 : ROW_W'(row_cnt_ff + ROW_W'(1));
         end else begin
            col_cnt_ff <= COL_W'(col_cnt_ff + COL_W'(1));
         end
      end
   end

   // ---------------------------------------------------------------------------------
   // Line store. Each entry holds the sample of the row above and of the row two above
   // for one column. Port A reads the item's own column, port B the column to its right.
   // The write of the item leaving stage 1 is forwarded to a read on the same edge.
   // ---------------------------------------------------------------------------------
   logic [2*W-1:0]   line_mem [MAX_COLS];
   logic [COL_W-1:0] rd_b_addr;
   logic [2*W-1:0]   wr_data;
   logic [2*W-1:0]   rd_a_ff;
   logic [W-1:0]     rd_b_ff;

   logic signed [W-1:0] s1_sample_ff;
   logic [ROW_W-1:0]    s1_row_ff;
   logic [COL_W-1:0]    s1_col_ff;
   logic                s1_last_row_ff;
   logic                s1_last_col_ff;

   assign rd_b_addr = at_last_col ? '0 : COL_W'(col_cnt_ff + COL_W'(1));

   always_ff @(posedge clock) begin
      if (s1_adv) begin
         line_mem[s1_col_ff] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         if (s1_adv && s1_col_ff == col_cnt_ff) begin
            rd_a_ff <= wr_data;
         end else begin
            rd_a_ff <= line_mem[col_cnt_ff];
         end
         if (s1_adv && s1_col_ff == rd_b_addr) begin
            rd_b_ff <= wr_data[2*W-1:W];
         end else begin
            rd_b_ff <= line_mem[rd_b_addr][2*W-1:W];
         end
      end
   end

   // ---------------------------------------------------------------------------------
   // Stage 1: decisions.
   // ---------------------------------------------------------------------------------
   logic signed [W-1:0] above_c;     // the centre of the upper decision
   logic signed [W-1:0] two_above_c; // its upper neighbour
   logic signed [W-1:0] above_r;     // its right neighbour
   logic signed [W-1:0] prev_above_ff; // the row above at the previous column
   logic signed [W-1:0] left_ff;
   logic signed [W-1:0] left_left_ff;

   assign above_c     = $signed(rd_a_ff[2*W-1:W]);
   assign two_above_c = $signed(rd_a_ff[W-1:0]);
   assign above_r     = $signed(rd_b_ff);
   // The old upper sample moves down to become the row two above.
   assign wr_data     = {s1_sample_ff, rd_a_ff[2*W-1:W]};

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (req_accept) begin
         s1_valid_ff <= 1'b1;
      end else if (s1_adv) begin
         s1_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         s1_sample_ff   <= req_ch.sample;
         s1_row_ff      <= row_cnt_ff;
         s1_col_ff      <= col_cnt_ff;
         s1_last_row_ff <= at_last_row;
         s1_last_col_ff <= at_last_col;
      end
   end

   always_comb begin
      s1_mask = '0;
      // Upper position: its lower neighbour is the current sample; the first row has
      // no upper neighbour, the first column no left one and the last column no right.
      if (s1_row_ff != '0) begin
         s1_mask.upper_pos = (above_c >= s1_sample_ff) &&
                             (s1_row_ff == ROW_W'(1) || above_c >= two_above_c) &&
                             (s1_col_ff == '0 || above_c >= prev_above_ff) &&
                             (s1_last_col_ff || above_c >= above_r);
      end
      // In the last row the previous sample is decided once its right neighbour is here.
      if (s1_last_row_ff && s1_col_ff != '0) begin
         s1_mask.left_pos = (left_ff >= s1_sample_ff) && (left_ff >= prev_above_ff) &&
                            (s1_col_ff == COL_W'(1) || left_ff >= left_left_ff);
      end
      // The final sample of the frame has only a left and an upper neighbour.
      if (s1_last_row_ff && s1_last_col_ff) begin
         s1_mask.final_pos = (s1_sample_ff >= left_ff) && (s1_sample_ff >= above_c);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         left_ff      <= '0;
         left_left_ff <= '0;
      end else if (s1_adv) begin
         left_ff      <= s1_sample_ff;
         left_left_ff <= left_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_adv) begin
         prev_above_ff <= above_c;
      end
   end

   // ---------------------------------------------------------------------------------
   // Stage 2: pending results of one item, handed out one per cycle unless stalled.
   // ---------------------------------------------------------------------------------
   logic [ROW_W-1:0] s2_row_ff;
   logic [COL_W-1:0] s2_col_ff;
   logic [ROW_W-1:0] out_row;
   logic [COL_W-1:0] out_col;

   always_comb begin
      if (s1_adv) begin
         s2_mask_in = s1_mask;
      end else if (s2_emit) begin
         s2_mask_in = s2_rest;
      end else begin
         s2_mask_in = s2_mask_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_mask_ff <= '0;
      end else begin
         s2_mask_ff <= s2_mask_in;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_adv) begin
         s2_row_ff <= s1_row_ff;
         s2_col_ff <= s1_col_ff;
      end
   end

   always_comb begin
      out_row = s2_row_ff;
      out_col = s2_col_ff;
      if (s2_sel.upper_pos) begin
         out_row = ROW_W'(s2_row_ff - ROW_W'(1));
      end else if (s2_sel.left_pos) begin
         out_col = COL_W'(s2_col_ff - COL_W'(1));
      end
   end

   // ---------------------------------------------------------------------------------
   // Output register.
   // ---------------------------------------------------------------------------------
   logic [PeakW-1:0] rsp_row_ff;
   logic [PeakW-1:0] rsp_col_ff;
   logic             rsp_last_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (s2_emit) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ch.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (s2_emit) begin
         rsp_row_ff  <= PeakW'(32'(out_row));
         rsp_col_ff  <= PeakW'(32'(out_col));
         rsp_last_ff <= (s2_rest == '0);
      end
   end

   assign rsp_ch.valid        = rsp_valid_ff;
   assign rsp_ch.peak_row     = rsp_row_ff;
   assign rsp_ch.peak_col     = rsp_col_ff;
   assign rsp_ch.last_of_item = rsp_last_ff;

endmodule

>>> rtl/gld_checker.sv
module gld_checker (
   input logic                      clock,
   input logic                      reset,
   input logic                      req_ready,
   input logic                      rsp_valid,
   input logic                      rsp_ready,
   input logic [gld_pkg::PeakW-1:0] rsp_peak_row,
   input logic [gld_pkg::PeakW-1:0] rsp_peak_col,
   input logic                      rsp_last_of_item
);

   // A result that is offered stays offered until it is taken.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("result withdrawn before it was taken");

   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> $stable(rsp_peak_row) && $stable(rsp_peak_col) &&
                                  $stable(rsp_last_of_item))
      else $error("result changed while stalled");

   // Reset empties the pipeline: nothing is offered and a new item can be taken.
   a_reset_no_rsp: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result offered straight after reset");

   a_reset_ready: assert property (@(posedge clock) reset |=> req_ready)
      else $error("input not ready straight after reset");

endmodule

bind grid_local_maximum_detector gld_checker u_gld_checker (
   .clock            (clock),
   .reset            (reset),
   .req_ready        (req_ch.ready),
   .rsp_valid        (rsp_ch.valid),
   .rsp_ready        (rsp_ch.ready),
   .rsp_peak_row     (rsp_ch.peak_row),
   .rsp_peak_col     (rsp_ch.peak_col),
   .rsp_last_of_item (rsp_ch.last_of_item)
);
